FILE: rtl/core/mlgs_pkg.sv
// shared types and constants for the masked life generation step
`default_nettype none

package mlgs_pkg;

   localparam int ROW_W         = 32;
   localparam int CFG_W         = 6;
   localparam int MAX_WIDTH_DEF = 32;
   localparam int COUNT_W       = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0]   WIDTH_RESET   = CFG_W'(32);
   localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);

   typedef struct packed {
      logic any_alive;
      logic any_diff;
   } row_flags_type;

   typedef struct packed {
      logic [ROW_W-1:0] next_cells;
      logic             frame_end;
      logic             all_dead;
      logic             no_change;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/mlgs_cell.sv
// one cell lane: neighbor count and the birth/survival rule
`default_nettype none

module mlgs_cell (
   input  logic [7:0] nbr,
   input  logic       alive,
   output logic       next_alive
);

   logic [mlgs_pkg::COUNT_W-1:0] n;

   always_comb begin
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + mlgs_pkg::COUNT_W'(nbr[i]);
      end
   end

   assign next_alive = (n == mlgs_pkg::BIRTH_COUNT) |
                       (alive & (n == mlgs_pkg::SURVIVE_COUNT));

endmodule

`default_nettype wire

FILE: rtl/core/mlgs_row.sv
// row of cell lanes with the merge of their results into row flags
`default_nettype none

module mlgs_row #(
   parameter int LANES = 32
) (
   input  logic [LANES-1:0]     above,
   input  logic [LANES-1:0]     mid,
   input  logic [LANES-1:0]     below,
   input  logic [LANES-1:0]     present,
   output logic [LANES-1:0]     next_row,
   output mlgs_pkg::row_flags_type flags
);

   // padded with a dead column on each side, no wrap
   logic [LANES+1:0] ap;
   logic [LANES+1:0] mp;
   logic [LANES+1:0] bp;
   logic [LANES-1:0] raw;

   assign ap = {1'b0, above, 1'b0};
   assign mp = {1'b0, mid, 1'b0};
   assign bp = {1'b0, below, 1'b0};

   for (genvar x = 0; x < LANES; x++) begin : g_lane
      mlgs_cell u_cell (
         .nbr        ({ap[x], ap[x+1], ap[x+2], mp[x], mp[x+2], bp[x], bp[x+1], bp[x+2]}),
         .alive      (mid[x]),
         .next_alive (raw[x])
      );
   end

   assign next_row        = raw & present;
   assign flags.any_alive = |next_row;
   assign flags.any_diff  = |((next_row ^ mid) & present);

endmodule

`default_nettype wire

FILE: rtl/core/mlgs_queue.sv
// small result queue taking up to two words a cycle and giving one unless stalled
`default_nettype none

module mlgs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_one,
   input  logic                   push_two,
   input  mlgs_pkg::rsp_word_type word_a,
   input  mlgs_pkg::rsp_word_type word_b,
   output logic                   room_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mlgs_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = mlgs_pkg::QPTR_W + 1;

   mlgs_pkg::rsp_word_type mem_ff [mlgs_pkg::QUEUE_DEPTH];

   logic [mlgs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mlgs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        pop;
   logic [CNT_W-1:0]            n_push;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   // two free slots needed before a word is taken
   assign room_ok   = (count_ff <= CNT_W'(mlgs_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      n_push    = push_two ? CNT_W'(2) : (push_one ? CNT_W'(1) : '0);
      wr_ptr_in = wr_ptr_ff + n_push[mlgs_pkg::QPTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + mlgs_pkg::QPTR_W'(pop);
      count_in  = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_one | push_two) begin
         mem_ff[wr_ptr_ff] <= word_a;
      end
      if (push_two) begin
         mem_ff[wr_ptr_ff + mlgs_pkg::QPTR_W'(1)] <= word_b;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/masked_life_generation_step.sv
// top level: line buffers, two lane rows, frame flags and result queue
`default_nettype none

// One Conway generation (birth on 3, survival on 2 or 3) over a grid that
// does not wrap. Rows enter top to bottom, one word per cycle, back to
// back unless stalled. Each row gives the next generation of the row above
// it; the bottom row (last_row) also gives its own, so one input word
// yields zero, one or two result words, the last one carrying frame_end
// with the all_dead and no_change flags for the whole frame. Both rows are
// computed in the cycle the word is taken, by two rows of MAX_WIDTH (at
// most 32) cell lanes, and land in a four-word queue; the result port
// drains one word per cycle unless stalled, so a sustained rate of one row
// per cycle holds. req_stall rises while the queue has fewer than two free
// slots. Columns at or beyond csr_width_in_use, or with a clear mask bit,
// are dead and read 0. Write the width only between frames while idle.
module masked_life_generation_step #(
   parameter int MAX_WIDTH = mlgs_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [mlgs_pkg::ROW_W-1:0] req_row_cells,
   input  logic [mlgs_pkg::ROW_W-1:0] req_row_mask,
   input  logic                       req_last_row,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mlgs_pkg::ROW_W-1:0] rsp_next_cells,
   output logic                       rsp_frame_end,
   output logic                       rsp_all_dead,
   output logic                       rsp_no_change,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mlgs_pkg::CFG_W-1:0] csr_width_in_use
);

   localparam int LANES = (MAX_WIDTH < mlgs_pkg::ROW_W) ? MAX_WIDTH : mlgs_pkg::ROW_W;

   logic [mlgs_pkg::CFG_W-1:0] width_ff;
   logic [LANES-1:0] older_cells_ff, older_mask_ff;
   logic [LANES-1:0] middle_cells_ff, middle_mask_ff;
   logic [1:0]       rows_seen_ff, rows_seen_in;
   logic             dead_ff, dead_in;
   logic             same_ff, same_in;

   logic             accept;
   logic             room_ok;
   logic [LANES-1:0] lim;
   logic [LANES-1:0] cur_p, cur_c, mid_p, mid_c, old_p, old_c, mid_for_b;
   logic [LANES-1:0] nx_a, nx_b;
   logic             has_a;
   logic             dead_a, same_a, dead_b, same_b;
   logic [mlgs_pkg::ROW_W-1:0] row_a, row_b;

   mlgs_pkg::row_flags_type flags_a, flags_b;
   mlgs_pkg::rsp_word_type  word_a, word_b, first_word, out_word;

   assign csr_ready = 1'b1;
   assign req_stall = ~room_ok;
   assign accept    = req_valid & room_ok;

   // column in use when below the width register
   for (genvar x = 0; x < LANES; x++) begin : g_lim
      assign lim[x] = (width_ff > mlgs_pkg::CFG_W'(x));
   end

   always_comb begin
      has_a     = (rows_seen_ff != 2'd0);
      cur_p     = req_row_mask[LANES-1:0] & lim;
      cur_c     = req_row_cells[LANES-1:0] & cur_p;
      mid_p     = middle_mask_ff & lim;
      mid_c     = middle_cells_ff & mid_p;
      old_p     = rows_seen_ff[1] ? (older_mask_ff & lim) : '0;
      old_c     = older_cells_ff & old_p;
      mid_for_b = has_a ? mid_c : '0;
   end

   mlgs_row #(.LANES(LANES)) u_row_a (
      .above    (old_c),
      .mid      (mid_c),
      .below    (cur_c),
      .present  (mid_p),
      .next_row (nx_a),
      .flags    (flags_a)
   );

   mlgs_row #(.LANES(LANES)) u_row_b (
      .above    (mid_for_b),
      .mid      (cur_c),
      .below    ('0),
      .present  (cur_p),
      .next_row (nx_b),
      .flags    (flags_b)
   );

   always_comb begin
      dead_a = dead_ff & ~(has_a & flags_a.any_alive);
      same_a = same_ff & ~(has_a & flags_a.any_diff);
      dead_b = dead_a & ~flags_b.any_alive;
      same_b = same_a & ~flags_b.any_diff;

      row_a = '0;
      row_a[LANES-1:0] = nx_a;
      row_b = '0;
      row_b[LANES-1:0] = nx_b;

      word_a.next_cells = row_a;
      word_a.frame_end  = 1'b0;
      word_a.all_dead   = 1'b0;
      word_a.no_change  = 1'b0;
      word_b.next_cells = row_b;
      word_b.frame_end  = 1'b1;
      word_b.all_dead   = dead_b;
      word_b.no_change  = same_b;

      first_word = has_a ? word_a : word_b;
   end

   always_comb begin
      rows_seen_in = rows_seen_ff;
      dead_in      = dead_ff;
      same_in      = same_ff;
      if (accept) begin
         if (req_last_row) begin
            rows_seen_in = 2'd0;
            dead_in      = 1'b1;
            same_in      = 1'b1;
         end else begin
            rows_seen_in = rows_seen_ff[1] ? 2'd2 : rows_seen_ff + 2'd1;
            dead_in      = dead_a;
            same_in      = same_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= mlgs_pkg::WIDTH_RESET;
         older_cells_ff  <= '0;
         older_mask_ff   <= '0;
         middle_cells_ff <= '0;
         middle_mask_ff  <= '0;
         rows_seen_ff    <= 2'd0;
         dead_ff         <= 1'b1;
         same_ff         <= 1'b1;
      end else begin
         if (csr_valid & csr_ready) begin
            width_ff <= csr_width_in_use;
         end
         rows_seen_ff <= rows_seen_in;
         dead_ff      <= dead_in;
         same_ff      <= same_in;
         if (accept) begin
            if (req_last_row) begin
               older_cells_ff  <= '0;
               older_mask_ff   <= '0;
               middle_cells_ff <= '0;
               middle_mask_ff  <= '0;
            end else begin
               older_cells_ff  <= middle_cells_ff;
               older_mask_ff   <= middle_mask_ff;
               middle_cells_ff <= req_row_cells[LANES-1:0];
               middle_mask_ff  <= req_row_mask[LANES-1:0];
            end
         end
      end
   end

   mlgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_one  (accept & (has_a ^ req_last_row)),
      .push_two  (accept & has_a & req_last_row),
      .word_a    (first_word),
      .word_b    (word_b),
      .room_ok   (room_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (out_word)
   );

   assign rsp_next_cells = out_word.next_cells;
   assign rsp_frame_end  = out_word.frame_end;
   assign rsp_all_dead   = out_word.all_dead;
   assign rsp_no_change  = out_word.no_change;

endmodule

`default_nettype wire

FILE: test/masked_life_generation_step_test.sv
// self-checking testbench for the masked life generation step
`timescale 1ns / 1ps

module masked_life_generation_step_test;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ROWS    = 182;

   class life_scoreboard;
      logic [mlgs_pkg::CFG_W-1:0] width;
      logic [mlgs_pkg::ROW_W-1:0] older_cells;
      logic [mlgs_pkg::ROW_W-1:0] older_mask;
      logic [mlgs_pkg::ROW_W-1:0] middle_cells;
      logic [mlgs_pkg::ROW_W-1:0] middle_mask;
      int unsigned                rows_seen;
      bit                         dead_so_far;
      bit                         same_so_far;
      mlgs_pkg::rsp_word_type     expected_words[$];
      int unsigned                errors;

      function new();
         width  = mlgs_pkg::WIDTH_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         older_cells  = '0;
         older_mask   = '0;
         middle_cells = '0;
         middle_mask  = '0;
         rows_seen    = 0;
         dead_so_far  = 1'b1;
         same_so_far  = 1'b1;
      endfunction

      // columns in use, capped at the row width
      function logic [mlgs_pkg::ROW_W-1:0] column_limit();
         int unsigned w;
         logic [63:0] ones;
         w = (width > mlgs_pkg::ROW_W) ? mlgs_pkg::ROW_W : width;
         ones = (64'd1 << w) - 64'd1;
         return (w == 0) ? '0 : ones[mlgs_pkg::ROW_W-1:0];
      endfunction

      function bit cell_at(logic [mlgs_pkg::ROW_W-1:0] v, int i);
         if (i < 0 || i >= mlgs_pkg::ROW_W)
            return 1'b0;
         return v[i];
      endfunction

      function logic [mlgs_pkg::ROW_W-1:0] next_generation(
            logic [mlgs_pkg::ROW_W-1:0] above,
            logic [mlgs_pkg::ROW_W-1:0] mid,
            logic [mlgs_pkg::ROW_W-1:0] below,
            logic [mlgs_pkg::ROW_W-1:0] present);
         logic [mlgs_pkg::ROW_W-1:0] res;
         int n;
         res = '0;
         for (int x = 0; x < mlgs_pkg::ROW_W; x++) begin
            n = 0;
            for (int dx = -1; dx <= 1; dx++) begin
               n += int'(cell_at(above, x + dx)) + int'(cell_at(below, x + dx));
               if (dx != 0)
                  n += int'(cell_at(mid, x + dx));
            end
            res[x] = mid[x] ? (n == 2 || n == 3) : (n == 3);
         end
         return res & present;
      endfunction

      function void add_expected(logic [mlgs_pkg::ROW_W-1:0] nx,
                                 logic [mlgs_pkg::ROW_W-1:0] old,
                                 logic [mlgs_pkg::ROW_W-1:0] present, bit last);
         mlgs_pkg::rsp_word_type w;
         if (nx != '0)
            dead_so_far = 1'b0;
         if (((nx ^ old) & present) != '0)
            same_so_far = 1'b0;
         w.next_cells = nx;
         w.frame_end  = last;
         w.all_dead   = last && dead_so_far;
         w.no_change  = last && same_so_far;
         expected_words.push_back(w);
      endfunction

      function void note_row(logic [mlgs_pkg::ROW_W-1:0] cells,
                             logic [mlgs_pkg::ROW_W-1:0] mask, bit last);
         logic [mlgs_pkg::ROW_W-1:0] lim, cur_p, cur_c, mid_p, mid_c, old_p, old_c;
         lim   = column_limit();
         cur_p = mask & lim;
         cur_c = cells & cur_p;
         mid_p = middle_mask & lim;
         mid_c = middle_cells & mid_p;
         old_p = (rows_seen >= 2) ? (older_mask & lim) : '0;
         old_c = (rows_seen >= 2) ? (older_cells & old_p) : '0;
         if (rows_seen >= 1)
            add_expected(next_generation(old_c, mid_c, cur_c, mid_p), mid_c, mid_p, 1'b0);
         else
            mid_c = '0;
         if (last) begin
            add_expected(next_generation(mid_c, cur_c, '0, cur_p), cur_c, cur_p, 1'b1);
            clear_frame();
         end else begin
            older_cells  = middle_cells;
            older_mask   = middle_mask;
            middle_cells = cells;
            middle_mask  = mask;
            if (rows_seen < 2)
               rows_seen++;
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void check_result(logic [mlgs_pkg::ROW_W-1:0] cells, logic fe, logic ad,
                                 logic nc);
         mlgs_pkg::rsp_word_type w;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: next_cells=%h", cells);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (cells !== w.next_cells) begin
            $error("next_cells expected %h actual %h", w.next_cells, cells);
            errors++;
         end
         if (fe !== w.frame_end) begin
            $error("frame_end expected %b actual %b", w.frame_end, fe);
            errors++;
         end
         if (ad !== w.all_dead) begin
            $error("all_dead expected %b actual %b", w.all_dead, ad);
            errors++;
         end
         if (nc !== w.no_change) begin
            $error("no_change expected %b actual %b", w.no_change, nc);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [mlgs_pkg::ROW_W-1:0] req_row_cells = '0;
   logic [mlgs_pkg::ROW_W-1:0] req_row_mask = '0;
   logic                       req_last_row = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [mlgs_pkg::ROW_W-1:0] rsp_next_cells;
   logic                       rsp_frame_end;
   logic                       rsp_all_dead;
   logic                       rsp_no_change;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [mlgs_pkg::CFG_W-1:0] csr_width_in_use = '0;

   life_scoreboard board = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sender_quiet = 0;
   int receiver_quiet = 0;
   int rows_sent = 0;
   int cycle_count = 0;

   masked_life_generation_step dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row_cells   (req_row_cells),
      .req_row_mask    (req_row_mask),
      .req_last_row    (req_last_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_cells  (rsp_next_cells),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_all_dead    (rsp_all_dead),
      .rsp_no_change   (rsp_no_change),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_width_in_use(csr_width_in_use)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: check accepted words, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_next_cells, rsp_frame_end, rsp_all_dead, rsp_no_change);
         if (receiver_quiet > 0)
            receiver_quiet--;
         else if ($urandom_range(199) == 0)
            receiver_quiet = $urandom_range(20, 60);
         rsp_stall <= (receiver_quiet == 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_row(input logic [mlgs_pkg::ROW_W-1:0] cells,
                           input logic [mlgs_pkg::ROW_W-1:0] mask,
                           input logic last);
      while (sender_quiet == 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (sender_quiet > 0)
         sender_quiet--;
      else if ($urandom_range(99) == 0)
         sender_quiet = $urandom_range(20, 60);
      req_valid     <= 1'b1;
      req_row_cells <= cells;
      req_row_mask  <= mask;
      req_last_row  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_row(cells, mask, last);
      rows_sent++;
   endtask

   // rows with no result may still be in flight, so settle a little after the drain
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_width(input logic [mlgs_pkg::CFG_W-1:0] w);
      wait_drained();
      csr_valid        <= 1'b1;
      csr_width_in_use <= w;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      board.width = w;
   endtask

   task automatic send_random_frame();
      int height;
      int density;
      int mask_kind;
      logic [mlgs_pkg::ROW_W-1:0] cells;
      logic [mlgs_pkg::ROW_W-1:0] mask;
      height    = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      density   = $urandom_range(5);
      mask_kind = $urandom_range(19);
      if ($urandom_range(39) == 0)
         wait_drained();
      for (int h = 0; h < height; h++) begin
         case (density)
            0: cells = '0;
            // stacked rows of blocks: a still life when the masks are full and no block is cut off
            1: cells = (h % 3 == 0) ? '0 : 32'h6666_6666;
            2: cells = $urandom() & $urandom() & $urandom();
            3: cells = $urandom() & $urandom();
            4: cells = $urandom();
            default: cells = $urandom() | $urandom();
         endcase
         if (mask_kind < 13)
            mask = '1;
         else if (mask_kind < 17)
            mask = $urandom();
         else if (mask_kind < 19)
            mask = $urandom() | $urandom();
         else
            mask = '0;
         send_row(cells, mask, h == height - 1);
      end
   endtask

   initial begin
      int widths[8];
      int target;
      widths = '{5, 63, 1, 31, 0, 33, 32, 0};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single row grids
      send_row('1, '1, 1'b1);
      send_row('0, '0, 1'b1);
      // block still life
      send_row('0, '1, 1'b0);
      send_row(32'h6, '1, 1'b0);
      send_row(32'h6, '1, 1'b0);
      send_row('0, '1, 1'b1);
      // blinker
      send_row('0, '1, 1'b0);
      send_row(32'h1c, '1, 1'b0);
      send_row('0, '1, 1'b1);
      // full rows, both edge columns
      send_row('1, '1, 1'b0);
      send_row('1, '1, 1'b0);
      send_row('1, '1, 1'b1);
      // top column edge
      send_row(32'h8000_0000, '1, 1'b0);
      send_row(32'hc000_0000, '1, 1'b0);
      send_row(32'h8000_0000, '1, 1'b1);
      // partial masks, then an empty two-row grid
      send_row('1, 32'haaaa_aaaa, 1'b0);
      send_row('1, 32'h5555_5555, 1'b1);
      send_row('0, '1, 1'b0);
      send_row('0, '1, 1'b1);

      for (int p = 0; p < 8; p++) begin
         set_width((p == 7) ? mlgs_pkg::CFG_W'($urandom_range(1, 63))
                            : mlgs_pkg::CFG_W'(widths[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         target = rows_sent + ((widths[p] == 0 && p != 7) ? 40 : PHASE_ROWS);
         while (rows_sent < target)
            send_random_frame();
      end

      wait_drained();
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
